@@ hdl/btc_pkg.sv @@
// Shared types and constants for the blob track classify counter.
// Used by the controller, datapath and top level; no dependencies.
package btc_pkg;

    localparam int unsigned AREA_BITS  = 24;
    localparam int unsigned COUNT_BITS = 16;
    localparam int unsigned RAD_BITS   = 13;
    localparam int unsigned IMGW_BITS  = 13;
    localparam int unsigned AGE_BITS   = 16;
    localparam int unsigned FIELD_BITS = 12;
    localparam int unsigned CLS_BITS   = 3;
    localparam int unsigned LIVE_BITS  = 5;
    localparam int unsigned ADDR_BITS  = 5;

    localparam logic [CLS_BITS-1:0] CLS_NONE   = 3'd0;
    localparam logic [CLS_BITS-1:0] CLS_BUS    = 3'd1;
    localparam logic [CLS_BITS-1:0] CLS_CAR    = 3'd2;
    localparam logic [CLS_BITS-1:0] CLS_PERSON = 3'd3;
    localparam logic [CLS_BITS-1:0] CLS_SMALL  = 3'd4;

    localparam logic [2:0] REG_BIG_AREA   = 3'd0;
    localparam logic [2:0] REG_SMALL_AREA = 3'd1;
    localparam logic [2:0] REG_RADIUS     = 3'd2;
    localparam logic [2:0] REG_MAX_AGE    = 3'd3;
    localparam logic [2:0] REG_IMG_WIDTH  = 3'd4;

    typedef enum logic [1:0] {
        P_MATCH1 = 2'b01,
        P_MATCH2 = 2'b10,
        P_EOF    = 2'b11
    } t_purpose;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic idx_inc;
        logic rd;
        logic calc;
        logic r2_load;
        logic wr_match;
        logic clr_valid;
        logic frame_inc;
        logic classify;
        logic ins;
        logic full_set;
        logic small_count;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic big;
        logic ent_valid;
        logic idx_last;
        logic hit;
        logic stale;
        logic scan_hit;
        logic cls_ok;
        logic small_ok;
        logic out_free;
    } t_status;

endpackage

@@ hdl/blob_track_classify_counter_core.sv @@
// Top level of the blob track classify counter: configuration registers,
// controller and datapath. Depends on btc_pkg, btc_ctrl and btc_dp.
//
// Input channel (i_valid / o_stall) carries a blob descriptor or, with
// i_mode high, an end-of-frame mark. Output channel (o_valid / i_stall)
// carries one result per request. Requests are taken one at a time: o_stall
// is low only while the controller is idle. A blob runs up to two match
// scans over the track table, a classify step and, for a new track, a
// free-slot search; an end-of-frame mark runs one scan that expires stale
// tracks. A scan steps past free slots and reads, measures and compares the
// live tracks in turn; this per-track scan over the single read port of the
// track RAM sets the rate. The result sits in an output register; a new
// request is taken while it waits, and the block holds in its final state
// only if a second result is ready before the first is taken. Synchronous
// reset empties the track table, zeroes the totals, sets the frame count to
// one and restores register defaults. Registers sit at byte addresses 4*i
// on the APB-style port.
module blob_track_classify_counter_core import btc_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned COORD_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_mode,
    input  logic [FIELD_BITS-1:0] i_box_x,
    input  logic [FIELD_BITS-1:0] i_box_y,
    input  logic [FIELD_BITS-1:0] i_box_width,
    input  logic [FIELD_BITS-1:0] i_box_height,
    input  logic [AREA_BITS-1:0]  i_blob_area,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CLS_BITS-1:0]   o_class_code,
    output logic                  o_matched,
    output logic                  o_table_full,
    output logic [COUNT_BITS-1:0] o_bus_total,
    output logic [COUNT_BITS-1:0] o_car_total,
    output logic [COUNT_BITS-1:0] o_people_total,
    output logic [LIVE_BITS-1:0]  o_live_tracks,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_BITS-1:0]  paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [AREA_BITS-1:0] r_big_area_min, r_small_area_min;
    logic [RAD_BITS-1:0]  r_match_radius;
    logic [AGE_BITS-1:0]  r_max_age;
    logic [IMGW_BITS-1:0] r_image_width;
    logic [2:0] reg_idx;
    logic cfg_wr, idle, req;
    t_cmd    cmd;
    t_status st;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_area_min   <= AREA_BITS'(1000);
            r_small_area_min <= AREA_BITS'(500);
            r_match_radius   <= RAD_BITS'(300);
            r_max_age        <= AGE_BITS'(10);
            r_image_width    <= IMGW_BITS'(640);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_BIG_AREA:   r_big_area_min   <= pwdata[AREA_BITS-1:0];
                REG_SMALL_AREA: r_small_area_min <= pwdata[AREA_BITS-1:0];
                REG_RADIUS:     r_match_radius   <= pwdata[RAD_BITS-1:0];
                REG_MAX_AGE:    r_max_age        <= pwdata[AGE_BITS-1:0];
                REG_IMG_WIDTH:  r_image_width    <= pwdata[IMGW_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BIG_AREA:   prdata = 32'(r_big_area_min);
            REG_SMALL_AREA: prdata = 32'(r_small_area_min);
            REG_RADIUS:     prdata = 32'(r_match_radius);
            REG_MAX_AGE:    prdata = 32'(r_max_age);
            REG_IMG_WIDTH:  prdata = 32'(r_image_width);
            default:        prdata = '0;
        endcase
    end

    assign o_stall = !idle;
    assign req     = i_valid && idle;

    btc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_mode  (i_mode),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    btc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_box_x          (i_box_x),
        .i_box_y          (i_box_y),
        .i_box_width      (i_box_width),
        .i_box_height     (i_box_height),
        .i_blob_area      (i_blob_area),
        .i_big_area_min   (r_big_area_min),
        .i_small_area_min (r_small_area_min),
        .i_match_radius   (r_match_radius),
        .i_max_age        (r_max_age),
        .i_image_width    (r_image_width),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_class_code     (o_class_code),
        .o_matched        (o_matched),
        .o_table_full     (o_table_full),
        .o_bus_total      (o_bus_total),
        .o_car_total      (o_car_total),
        .o_people_total   (o_people_total),
        .o_live_tracks    (o_live_tracks)
    );

endmodule

@@ hdl/btc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module btc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/btc_ctrl.sv @@
// Controller state machine: sequences match scans, classify, insert and
// end-of-frame expiry. Depends on btc_pkg.
module btc_ctrl import btc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req,
    input  logic    i_mode,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_idle
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PREP  = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_WAIT  = 10'b0000001000,
        S_CMP   = 10'b0000010000,
        S_END   = 10'b0000100000,
        S_CLASS = 10'b0001000000,
        S_FREE  = 10'b0010000000,
        S_SMALL = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state   r_state, n_state;
    t_purpose r_purp, n_purp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_purp  <= P_MATCH1;
        end else begin
            r_state <= n_state;
            r_purp  <= n_purp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_purp  = r_purp;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    if (i_mode) begin
                        n_purp  = P_EOF;
                        n_state = S_RD;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.r2_load = 1'b1;
                if (i_st.big) begin
                    n_purp  = P_MATCH1;
                    n_state = S_RD;
                end else begin
                    n_state = S_CLASS;
                end
            end
            S_RD: begin
                if (i_st.ent_valid) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_WAIT;
                end else if (i_st.idx_last) begin
                    n_state = S_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_WAIT: begin
                o_cmd.calc = 1'b1;
                n_state    = S_CMP;
            end
            S_CMP: begin
                if (r_purp == P_EOF) begin
                    o_cmd.clr_valid = i_st.stale;
                    if (i_st.idx_last) begin
                        n_state = S_END;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RD;
                    end
                end else if (i_st.hit) begin
                    o_cmd.wr_match = 1'b1;
                    n_state        = S_END;
                end else if (i_st.idx_last) begin
                    n_state = S_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_END: begin
                case (r_purp)
                    P_EOF: begin
                        o_cmd.frame_inc = 1'b1;
                        n_state         = S_OUT;
                    end
                    P_MATCH2: begin
                        o_cmd.small_count = !i_st.scan_hit;
                        n_state           = S_OUT;
                    end
                    default: begin
                        n_state = S_CLASS;
                    end
                endcase
            end
            S_CLASS: begin
                if (i_st.cls_ok) begin
                    o_cmd.classify = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_FREE;
                end else begin
                    n_state = S_SMALL;
                end
            end
            S_FREE: begin
                if (!i_st.ent_valid) begin
                    o_cmd.ins = 1'b1;
                    n_state   = S_SMALL;
                end else if (i_st.idx_last) begin
                    o_cmd.full_set = 1'b1;
                    n_state        = S_SMALL;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SMALL: begin
                if (i_st.small_ok) begin
                    o_cmd.scan_clr = 1'b1;
                    n_purp         = P_MATCH2;
                    n_state        = S_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

@@ hdl/btc_dp.sv @@
// Datapath: request registers, track table, distance and age checks,
// counters and output register. Depends on btc_pkg and btc_ram.
module btc_dp import btc_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned COORD_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_st,
    input  logic [FIELD_BITS-1:0] i_box_x,
    input  logic [FIELD_BITS-1:0] i_box_y,
    input  logic [FIELD_BITS-1:0] i_box_width,
    input  logic [FIELD_BITS-1:0] i_box_height,
    input  logic [AREA_BITS-1:0]  i_blob_area,
    input  logic [AREA_BITS-1:0]  i_big_area_min,
    input  logic [AREA_BITS-1:0]  i_small_area_min,
    input  logic [RAD_BITS-1:0]   i_match_radius,
    input  logic [AGE_BITS-1:0]   i_max_age,
    input  logic [IMGW_BITS-1:0]  i_image_width,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [CLS_BITS-1:0]   o_class_code,
    output logic                  o_matched,
    output logic                  o_table_full,
    output logic [COUNT_BITS-1:0] o_bus_total,
    output logic [COUNT_BITS-1:0] o_car_total,
    output logic [COUNT_BITS-1:0] o_people_total,
    output logic [LIVE_BITS-1:0]  o_live_tracks
);

    localparam int unsigned IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned LW   = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CW   = COORD_BITS;
    localparam int unsigned SQW  = 2 * CW;
    localparam int unsigned R2W  = 2 * RAD_BITS;
    localparam int unsigned DW   = 33;
    localparam int unsigned EW   = CW + 3;
    localparam int unsigned RAMW = 2 * CW + COUNT_BITS;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    localparam logic [COUNT_BITS-1:0] SAT = {COUNT_BITS{1'b1}};

    logic [CW-1:0] r_x, r_y, r_w, r_h, r_cx, r_cy;
    logic [AREA_BITS-1:0] r_area;
    logic [R2W-1:0] r_r2;
    logic [IW-1:0] r_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [LW-1:0] r_live;
    logic [SQW-1:0] r_sqx, r_sqy;
    logic r_stale, r_hit, r_matched, r_full;
    logic [CLS_BITS-1:0] r_cls;
    logic [COUNT_BITS-1:0] r_frame, r_bus, r_car, r_person;

    logic [CW-1:0] in_x, in_y, in_w, in_h;
    logic [CW:0] sum_cx, sum_cy;
    logic [RAMW-1:0] ram_rdata, ram_wdata;
    logic [CW-1:0] trk_x, trk_y, adx, ady;
    logic [COUNT_BITS-1:0] trk_frame, age;
    logic [DW-1:0] d2;
    logic [EW-1:0] right_big, right_small;
    logic win_big, cls_small_ok;
    logic [CLS_BITS-1:0] cls_new;
    logic out_free;

    assign in_x   = CW'(i_box_x);
    assign in_y   = CW'(i_box_y);
    assign in_w   = CW'(i_box_width);
    assign in_h   = CW'(i_box_height);
    assign sum_cx = {1'b0, in_x} + {2'b0, in_w[CW-1:1]};
    assign sum_cy = {1'b0, in_y} + {2'b0, in_h[CW-1:1]};

    assign ram_wdata = {r_cx, r_cy, r_frame};

    btc_ram #(
        .WIDTH (RAMW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_match || i_cmd.ins),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign trk_x     = ram_rdata[RAMW-1 -: CW];
    assign trk_y     = ram_rdata[COUNT_BITS +: CW];
    assign trk_frame = ram_rdata[COUNT_BITS-1:0];
    assign adx       = (r_cx >= trk_x) ? (r_cx - trk_x) : (trk_x - r_cx);
    assign ady       = (r_cy >= trk_y) ? (r_cy - trk_y) : (trk_y - r_cy);
    assign age       = r_frame - trk_frame;
    assign d2        = DW'(r_sqx) + DW'(r_sqy);

    assign right_big   = EW'(r_x) + EW'(r_w) + EW'(1);
    assign right_small = EW'(r_x) + EW'(r_w) + EW'(4);

    assign win_big = (r_area > i_big_area_min) && (r_y > CW'(50)) && (r_x > CW'(1))
                     && (EW'(right_big) < EW'(i_image_width));

    always_comb begin
        if (r_h > CW'(60) && r_h < CW'(90) && r_w > CW'(250)) begin
            cls_new = CLS_BUS;
        end else if (r_w > CW'(80) && r_h < CW'(60) && r_h > CW'(30)) begin
            cls_new = CLS_CAR;
        end else if (r_h > CW'(30)) begin
            cls_new = CLS_PERSON;
        end else begin
            cls_new = CLS_NONE;
        end
    end

    assign cls_small_ok = (r_cls != CLS_PERSON) && (r_y > CW'(60)) && (r_x > CW'(4))
                          && (EW'(right_small) < EW'(i_image_width))
                          && (r_area > i_small_area_min)
                          && (r_w < CW'(50)) && (r_h > CW'(50));

    assign out_free = !o_valid || !i_stall;

    assign o_st.big       = (r_area > i_big_area_min);
    assign o_st.ent_valid = r_valid[r_idx];
    assign o_st.idx_last  = (r_idx == IW'(TABLE_DEPTH - 1));
    assign o_st.hit       = (d2 < DW'(r_r2));
    assign o_st.stale     = r_stale;
    assign o_st.scan_hit  = r_hit;
    assign o_st.cls_ok    = win_big && !r_hit && (cls_new != CLS_NONE);
    assign o_st.small_ok  = cls_small_ok;
    assign o_st.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= in_x;
            r_y    <= in_y;
            r_w    <= in_w;
            r_h    <= in_h;
            r_area <= i_blob_area;
            r_cx   <= sum_cx[CW] ? CMAX : sum_cx[CW-1:0];
            r_cy   <= sum_cy[CW] ? CMAX : sum_cy[CW-1:0];
        end
        if (i_cmd.r2_load) begin
            r_r2 <= R2W'(i_match_radius) * R2W'(i_match_radius);
        end
        if (i_cmd.calc) begin
            r_sqx   <= SQW'(adx) * SQW'(adx);
            r_sqy   <= SQW'(ady) * SQW'(ady);
            r_stale <= (age > i_max_age);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_valid   <= '0;
            r_live    <= '0;
            r_hit     <= 1'b0;
            r_matched <= 1'b0;
            r_full    <= 1'b0;
            r_cls     <= CLS_NONE;
            r_frame   <= COUNT_BITS'(1);
            r_bus     <= '0;
            r_car     <= '0;
            r_person  <= '0;
        end else begin
            if (i_cmd.scan_clr) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.load) begin
                r_matched <= 1'b0;
                r_full    <= 1'b0;
                r_cls     <= CLS_NONE;
            end
            if (i_cmd.wr_match) begin
                r_hit     <= 1'b1;
                r_matched <= 1'b1;
            end
            if (i_cmd.clr_valid) begin
                r_valid[r_idx] <= 1'b0;
                r_live         <= r_live - LW'(1);
            end
            if (i_cmd.ins) begin
                r_valid[r_idx] <= 1'b1;
                r_live         <= r_live + LW'(1);
            end
            if (i_cmd.full_set) begin
                r_full <= 1'b1;
            end
            if (i_cmd.frame_inc) begin
                r_frame <= r_frame + COUNT_BITS'(1);
            end
            if (i_cmd.classify) begin
                r_cls <= cls_new;
                case (cls_new)
                    CLS_BUS: begin
                        if (r_bus != SAT) r_bus <= r_bus + COUNT_BITS'(1);
                    end
                    CLS_CAR: begin
                        if (r_car != SAT) r_car <= r_car + COUNT_BITS'(1);
                    end
                    default: begin
                        if (r_person != SAT) r_person <= r_person + COUNT_BITS'(1);
                    end
                endcase
            end
            if (i_cmd.small_count) begin
                r_cls <= CLS_SMALL;
                if (r_person != SAT) r_person <= r_person + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_class_code   <= r_cls;
            o_matched      <= r_matched;
            o_table_full   <= r_full;
            o_bus_total    <= r_bus;
            o_car_total    <= r_car;
            o_people_total <= r_person;
            o_live_tracks  <= (32'(r_live) > 32'd31) ? LIVE_BITS'(31) : LIVE_BITS'(r_live);
        end
    end

endmodule

@@ verif/tb.sv @@
// Testbench for blob_track_classify_counter_core: drives blob and end-of-frame
// requests, predicts each result with an internal tracker model and checks it.
// Depends on btc_pkg and the core RTL.
module tb;
    import btc_pkg::*;

    typedef struct packed {
        logic                  mode;
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [FIELD_BITS-1:0] w;
        logic [FIELD_BITS-1:0] h;
        logic [AREA_BITS-1:0]  area;
    } t_blob_req;

    typedef struct packed {
        logic [CLS_BITS-1:0]   cls;
        logic                  matched;
        logic                  full;
        logic [COUNT_BITS-1:0] bus;
        logic [COUNT_BITS-1:0] car;
        logic [COUNT_BITS-1:0] people;
        logic [LIVE_BITS-1:0]  live;
    } t_tally;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_mode = 1'b0;
    logic [FIELD_BITS-1:0] i_box_x = '0, i_box_y = '0, i_box_width = '0, i_box_height = '0;
    logic [AREA_BITS-1:0] i_blob_area = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [CLS_BITS-1:0] o_class_code;
    logic o_matched, o_table_full;
    logic [COUNT_BITS-1:0] o_bus_total, o_car_total, o_people_total;
    logic [LIVE_BITS-1:0] o_live_tracks;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    blob_track_classify_counter_core u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tracker model state
    logic [23:0] big_min, small_min;
    logic [12:0] radius, img_w;
    logic [15:0] age_max, frame_no;
    logic [DEPTH-1:0] trk_valid;
    logic [11:0] trk_cx [DEPTH];
    logic [11:0] trk_cy [DEPTH];
    logic [15:0] trk_frame [DEPTH];
    logic [15:0] n_bus, n_car, n_people;

    t_blob_req pending_reqs[$];
    t_tally    expected_tallies[$];
    int errors = 0;
    bit rx_hold = 1'b0;
    bit rx_free_run = 1'b0;
    bit tx_free_run = 1'b0;
    int quiet_cycles = 0;

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [11:0] centre(logic [11:0] p, logic [11:0] l);
        int c;
        c = p + l / 2;
        return (c > 4095) ? 12'hFFF : c[11:0];
    endfunction

    function automatic bit refresh_track(logic [11:0] cx, logic [11:0] cy);
        longint r2, dx, dy;
        r2 = longint'(radius) * radius;
        for (int i = 0; i < DEPTH; i++) begin
            if (!trk_valid[i]) continue;
            dx = longint'(cx) - trk_cx[i];
            dy = longint'(cy) - trk_cy[i];
            if (dx * dx + dy * dy < r2) begin
                trk_cx[i] = cx;
                trk_cy[i] = cy;
                trk_frame[i] = frame_no;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_tally track_blob(t_blob_req r);
        t_tally t;
        logic [11:0] cx, cy;
        bit hit, person_added;
        int slot, live, xw;
        t = '0;
        hit = 1'b0;
        person_added = 1'b0;
        if (r.mode) begin
            for (int i = 0; i < DEPTH; i++)
                if (trk_valid[i] && 16'(frame_no - trk_frame[i]) > age_max)
                    trk_valid[i] = 1'b0;
            frame_no = frame_no + 16'd1;
        end else begin
            cx = centre(r.x, r.w);
            cy = centre(r.y, r.h);
            xw = r.x + r.w;
            if (r.area > big_min) begin
                hit = refresh_track(cx, cy);
                t.matched = hit;
            end
            if (r.area > big_min && r.y > 50 && r.x > 1 && xw + 1 < img_w && !hit) begin
                if (r.h > 60 && r.h < 90 && r.w > 250) begin
                    n_bus = sat_inc(n_bus);
                    t.cls = CLS_BUS;
                end else if (r.w > 80 && r.h < 60 && r.h > 30) begin
                    n_car = sat_inc(n_car);
                    t.cls = CLS_CAR;
                end else if (r.h > 30) begin
                    n_people = sat_inc(n_people);
                    person_added = 1'b1;
                    t.cls = CLS_PERSON;
                end
                if (t.cls != CLS_NONE) begin
                    slot = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (!trk_valid[i] && slot < 0) slot = i;
                    if (slot < 0) begin
                        t.full = 1'b1;
                    end else begin
                        trk_valid[slot] = 1'b1;
                        trk_cx[slot] = cx;
                        trk_cy[slot] = cy;
                        trk_frame[slot] = frame_no;
                    end
                end
            end
            if (!person_added && r.y > 60 && r.x > 4 && xw + 4 < img_w &&
                    r.area > small_min && r.w < 50 && r.h > 50) begin
                if (refresh_track(cx, cy)) begin
                    t.matched = 1'b1;
                end else begin
                    n_people = sat_inc(n_people);
                    t.cls = CLS_SMALL;
                end
            end
        end
        live = $countones(trk_valid);
        t.bus = n_bus;
        t.car = n_car;
        t.people = n_people;
        t.live = live[4:0];
        return t;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_reqs.size() > 0 && (tx_free_run || $urandom_range(99) >= 24)) begin
                    t_blob_req r;
                    r = pending_reqs.pop_front();
                    expected_tallies.insert(expected_tallies.size(), track_blob(r));
                    i_valid <= 1'b1;
                    {i_mode, i_box_x, i_box_y, i_box_width, i_box_height, i_blob_area} <= r;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_tallies.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    t_tally e;
                    e = expected_tallies.pop_front();
                    if (o_class_code !== e.cls) report("class_code", o_class_code, e.cls);
                    if (o_matched !== e.matched) report("matched", o_matched, e.matched);
                    if (o_table_full !== e.full) report("table_full", o_table_full, e.full);
                    if (o_bus_total !== e.bus) report("bus_total", o_bus_total, e.bus);
                    if (o_car_total !== e.car) report("car_total", o_car_total, e.car);
                    if (o_people_total !== e.people)
                        report("people_total", o_people_total, e.people);
                    if (o_live_tracks !== e.live) report("live_tracks", o_live_tracks, e.live);
                end
            end
            i_stall <= rx_hold || (!rx_free_run && $urandom_range(99) < 24);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[blob_track_classify_counter_core] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_BITS'(idx) << 2;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BIG_AREA:   big_min = val[23:0];
            REG_SMALL_AREA: small_min = val[23:0];
            REG_RADIUS:     radius = val[12:0];
            REG_MAX_AGE:    age_max = val[15:0];
            REG_IMG_WIDTH:  img_w = val[12:0];
            default: ;
        endcase
    endtask

    task automatic add_req(t_blob_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_tallies.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_blob_req mk(bit m, int x, int y, int w, int h, int a);
        t_blob_req r;
        r.mode = m;
        r.x = FIELD_BITS'(x);
        r.y = FIELD_BITS'(y);
        r.w = FIELD_BITS'(w);
        r.h = FIELD_BITS'(h);
        r.area = AREA_BITS'(a);
        return r;
    endfunction

    function automatic t_blob_req rand_blob();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) return mk(1, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (pick < 22) return mk(0, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (pick < 40)
            return mk(0, $urandom_range(2, 300), $urandom_range(51, 500), $urandom_range(251, 320),
                      $urandom_range(61, 89), $urandom_range(1001, 40000));
        if (pick < 58)
            return mk(0, $urandom_range(2, 500), $urandom_range(51, 500), $urandom_range(81, 130),
                      $urandom_range(31, 59), $urandom_range(1001, 9000));
        if (pick < 78)
            return mk(0, $urandom_range(2, 580), $urandom_range(51, 500), $urandom_range(0, 50),
                      $urandom_range(25, 200), $urandom_range(900, 3000));
        return mk(0, $urandom_range(5, 580), $urandom_range(61, 500), $urandom_range(0, 49),
                  $urandom_range(51, 150), $urandom_range(400, 1000));
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) add_req(rand_blob());
        drain();
    endtask

    initial begin
        big_min = 24'd1000;
        small_min = 24'd500;
        radius = 13'd300;
        age_max = 16'd10;
        img_w = 13'd640;
        trk_valid = '0;
        frame_no = 16'd1;
        n_bus = '0;
        n_car = '0;
        n_people = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: each class, small person, match, expiry, extremes
        add_req(mk(0, 10, 100, 300, 70, 5000));
        add_req(mk(0, 10, 100, 300, 70, 5000));
        add_req(mk(0, 300, 300, 100, 40, 2000));
        add_req(mk(0, 500, 60, 20, 100, 1500));
        add_req(mk(0, 100, 400, 20, 100, 600));
        add_req(mk(0, 500, 60, 20, 100, 600));
        add_req(mk(0, 10, 100, 300, 20, 5000));
        add_req(mk(0, 4095, 4095, 4095, 4095, 24'hFFFFFF));
        add_req(mk(0, 0, 0, 0, 0, 0));
        add_req(mk(0, 1, 50, 300, 70, 1001));
        for (int i = 0; i < 12; i++) add_req(mk(1, 0, 0, 0, 0, 0));
        drain();

        random_phase(150);

        // dense table: radius zero, then fill past capacity
        write_reg(REG_RADIUS, 32'd0);
        write_reg(REG_MAX_AGE, 32'd65535);
        for (int i = 0; i < 20; i++)
            add_req(mk(0, 2 + i * 20, 60, 30, 100, 2000));
        drain();
        random_phase(100);

        // receiver holds off while requests keep coming
        write_reg(REG_RADIUS, 32'd8191);
        write_reg(REG_MAX_AGE, 32'd0);
        rx_hold = 1'b1;
        for (int i = 0; i < 30; i++) add_req(rand_blob());
        repeat (400) @(posedge i_clk);
        rx_hold = 1'b0;
        drain();

        write_reg(REG_BIG_AREA, 32'hFFFFFF);
        write_reg(REG_SMALL_AREA, 32'd0);
        write_reg(REG_IMG_WIDTH, 32'd4096);
        write_reg(REG_RADIUS, 32'd40);
        write_reg(REG_MAX_AGE, 32'd3);
        random_phase(80);

        write_reg(REG_BIG_AREA, 32'd0);
        write_reg(REG_SMALL_AREA, 32'hFFFFFF);
        write_reg(REG_IMG_WIDTH, 32'd1);
        random_phase(60);

        write_reg(REG_BIG_AREA, 32'd1000);
        write_reg(REG_SMALL_AREA, 32'd500);
        write_reg(REG_IMG_WIDTH, 32'd640);
        write_reg(REG_RADIUS, 32'd100);
        write_reg(REG_MAX_AGE, 32'd5);
        rx_free_run = 1'b1;
        tx_free_run = 1'b1;
        random_phase(120);
        rx_free_run = 1'b0;
        tx_free_run = 1'b0;
        random_phase(200);

        if (errors == 0) begin
            $display("[blob_track_classify_counter_core] OK");
        end else begin
            $display("[blob_track_classify_counter_core] ERROR");
        end
        $finish;
    end
endmodule

@@ blob_track_classify_counter_core.f @@
hdl/btc_pkg.sv
hdl/btc_ram.sv
hdl/btc_ctrl.sv
hdl/btc_dp.sv
hdl/blob_track_classify_counter_core.sv
verif/tb.sv
